// ===== hdl/dtio_pkg.sv =====
// ----------------------------------------------------------------------------
// dtio_pkg
// Shared types and codes for the device table with oldest-entry replacement.
// ----------------------------------------------------------------------------
package dtio_pkg;

   localparam int VENDOR_W  = 8;
   localparam int ADDRESS_W = 16;
   localparam int TIME_W    = 32;
   localparam int PAYLOAD_W = 64;
   localparam int SLOT_W    = 4;
   localparam int OUTCOME_W = 2;
   localparam int KEY_W     = VENDOR_W + ADDRESS_W + TIME_W;

   typedef enum logic [OUTCOME_W-1:0] {
      OUTCOME_MATCH  = 2'd0,
      OUTCOME_FREE   = 2'd1,
      OUTCOME_OLDEST = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [VENDOR_W-1:0]  vendor_id;
      logic [ADDRESS_W-1:0] device_address;
      logic [TIME_W-1:0]    receive_time;
      logic [PAYLOAD_W-1:0] record_payload;
   } req_word_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } queue_head_type;

endpackage

// ===== hdl/dtio_req_if.sv =====
// ----------------------------------------------------------------------------
// dtio_req_if
// Valid/ready channel carrying one received device record.
// ----------------------------------------------------------------------------
interface dtio_req_if;
   logic                           valid;
   logic                           ready;
   logic [dtio_pkg::VENDOR_W-1:0]  vendor_id;
   logic [dtio_pkg::ADDRESS_W-1:0] device_address;
   logic [dtio_pkg::TIME_W-1:0]    receive_time;
   logic [dtio_pkg::PAYLOAD_W-1:0] record_payload;

   modport source (output valid, vendor_id, device_address, receive_time, record_payload,
                   input ready);
   modport sink (input valid, vendor_id, device_address, receive_time, record_payload,
                 output ready);
endinterface

// ===== hdl/dtio_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dtio_rsp_if
// Valid/ready channel carrying the chosen slot and the outcome code.
// ----------------------------------------------------------------------------
interface dtio_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dtio_pkg::SLOT_W-1:0]    slot_index;
   logic [dtio_pkg::OUTCOME_W-1:0] outcome;

   modport source (output valid, slot_index, outcome, input ready);
   modport sink (input valid, slot_index, outcome, output ready);
endinterface

// ===== hdl/dtio_ram.sv =====
// ----------------------------------------------------------------------------
// dtio_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/dtio_front.sv =====
// ----------------------------------------------------------------------------
// dtio_front
// Accepts records and holds them in a two-word queue for the table engine.
// ----------------------------------------------------------------------------
module dtio_front (
   input  logic                     clock,
   input  logic                     reset,
   dtio_req_if.sink                 req_ch,
   output dtio_pkg::queue_head_type head,
   input  logic                     pop
);

   dtio_pkg::req_word_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       take;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign take         = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ take;
      count_in  = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].vendor_id      <= req_ch.vendor_id;
         slot_ff[wr_ptr_ff].device_address <= req_ch.device_address;
         slot_ff[wr_ptr_ff].receive_time   <= req_ch.receive_time;
         slot_ff[wr_ptr_ff].record_payload <= req_ch.record_payload;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/dtio_engine.sv =====
// ----------------------------------------------------------------------------
// dtio_engine
// Scans the table one entry per cycle, picks the slot, writes the record
// and posts the result word.
// ----------------------------------------------------------------------------
module dtio_engine #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PAYLOAD_BITS  = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dtio_pkg::queue_head_type head,
   output logic                     pop,
   dtio_rsp_if.source               rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        issue_ff, issue_in;
   logic [IDX_W-1:0]            proc_idx_ff, proc_idx_in;
   logic                        proc_vld_ff, proc_vld_in;
   logic                        match_found_ff, match_found_in;
   logic [IDX_W-1:0]            match_idx_ff, match_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [dtio_pkg::TIME_W-1:0] min_time_ff, min_time_in;
   logic [IDX_W-1:0]            min_idx_ff, min_idx_in;
   logic [TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dtio_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   dtio_pkg::outcome_type       rsp_outcome_ff, rsp_outcome_in;
   dtio_pkg::req_word_type      work_ff;

   logic [dtio_pkg::KEY_W-1:0]     key_rd;
   logic [dtio_pkg::VENDOR_W-1:0]  rd_vendor;
   logic [dtio_pkg::ADDRESS_W-1:0] rd_address;
   logic [dtio_pkg::TIME_W-1:0]    rd_time;
   logic                           entry_used;
   logic                           out_free;
   logic                           commit;
   logic [IDX_W-1:0]               slot_sel;
   dtio_pkg::outcome_type          outcome_sel;
   logic [IDX_W+dtio_pkg::SLOT_W-1:0] slot_wide;

   assign {rd_vendor, rd_address, rd_time} = key_rd;
   assign entry_used = valid_ff[proc_idx_ff] && (rd_time != '0);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign commit     = (state_ff == ST_WRITE) && out_free;
   assign pop        = (state_ff == ST_IDLE) && head.valid;

   // first rule that applies decides
   always_comb begin
      priority if (match_found_ff) begin
         slot_sel    = match_idx_ff;
         outcome_sel = dtio_pkg::OUTCOME_MATCH;
      end else if (free_found_ff) begin
         slot_sel    = free_idx_ff;
         outcome_sel = dtio_pkg::OUTCOME_FREE;
      end else begin
         slot_sel    = min_idx_ff;
         outcome_sel = dtio_pkg::OUTCOME_OLDEST;
      end
   end

   assign slot_wide = {{dtio_pkg::SLOT_W{1'b0}}, slot_sel};

   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      issue_in       = issue_ff;
      proc_idx_in    = rd_idx_ff;
      proc_vld_in    = 1'b0;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_time_in    = min_time_ff;
      min_idx_in     = min_idx_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_outcome_in = rsp_outcome_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               state_in       = ST_SCAN;
               rd_idx_in      = '0;
               issue_in       = 1'b1;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            proc_vld_in = issue_ff;
            if (issue_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (proc_vld_ff) begin
               if (entry_used && !match_found_ff &&
                   rd_vendor == work_ff.vendor_id &&
                   rd_address == work_ff.device_address) begin
                  match_found_in = 1'b1;
                  match_idx_in   = proc_idx_ff;
               end
               if (!entry_used && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx_ff;
               end
               // strict less keeps the lowest index on a tie
               if (proc_idx_ff == '0 || rd_time < min_time_ff) begin
                  min_time_in = rd_time;
                  min_idx_in  = proc_idx_ff;
               end
               if (proc_idx_ff == LAST_IDX) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               valid_in[slot_sel] = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_slot_in        = slot_wide[dtio_pkg::SLOT_W-1:0];
               rsp_outcome_in     = outcome_sel;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_ff       <= 1'b0;
         proc_vld_ff    <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_ff       <= issue_in;
         proc_vld_ff    <= proc_vld_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      proc_idx_ff    <= proc_idx_in;
      match_idx_ff   <= match_idx_in;
      free_idx_ff    <= free_idx_in;
      min_time_ff    <= min_time_in;
      min_idx_ff     <= min_idx_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      if (pop) begin
         work_ff <= head.word;
      end
   end

   dtio_ram #(
      .WIDTH (dtio_pkg::KEY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot_sel),
      .wr_data ({work_ff.vendor_id, work_ff.device_address, work_ff.receive_time}),
      .rd_en   (issue_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (key_rd)
   );

   // payload is stored with the entry, never read back here
   dtio_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (slot_sel),
      .wr_data (work_ff.record_payload[PAYLOAD_BITS-1:0]),
      .rd_en   (1'b0),
      .rd_addr (slot_sel),
      .rd_data ()
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;
   assign rsp_ch.outcome    = rsp_outcome_ff;

`ifndef NO_ASSERTIONS
   a_proc_in_scan: assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> state_ff == ST_SCAN)
      else $error("entry processed outside scan");
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("result posted without a table write");
   a_oldest_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !match_found_ff && !free_found_ff) |-> &valid_ff)
      else $error("oldest replacement with an unwritten entry");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_SCAN && issue_ff && rd_idx_ff == '0)
      else $error("scan did not start after pop");
`endif

endmodule

// ===== hdl/device_table_insert_oldest_evict.sv =====
// ----------------------------------------------------------------------------
// device_table_insert_oldest_evict
// Device table: update on key match, else fill lowest free entry, else
// replace the entry with the smallest timestamp.
// ----------------------------------------------------------------------------
//   channel  dir  words carried
//   req_ch   in   vendor_id, device_address, receive_time, record_payload
//   rsp_ch   out  slot_index, outcome
//
// Each record passes through a start step, one read per entry of the key
// RAM through its single read port, the registered read and a write that
// waits until the result register can take it. Records queue two deep ahead
// of the table; the result register lets the next scan run while a result
// waits. Reset clears all entry valid bits at once, so every entry is free.
// ----------------------------------------------------------------------------
module device_table_insert_oldest_evict #(
   parameter int TABLE_ENTRIES = 16,
   parameter int PAYLOAD_BITS  = 64
) (
   input logic        clock,
   input logic        reset,
   dtio_req_if.sink   req_ch,
   dtio_rsp_if.source rsp_ch
);

   dtio_pkg::queue_head_type head;
   logic                     pop;

   dtio_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   dtio_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PAYLOAD_BITS  (PAYLOAD_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== test/dtio_placement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtio_placement_checker
// Watches both channels of the device table, predicts the slot and outcome of
// every accepted record from a private copy of the table, and compares each
// accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dtio_placement_checker (
   input  logic  clock,
   input  logic  reset,
   dtio_req_if   req_mon,
   dtio_rsp_if   rsp_mon,
   output int    mismatch_count,
   output int    results_pending,
   output int    match_seen,
   output int    free_seen,
   output int    oldest_seen
);

   localparam int ENTRIES = 16;

   typedef struct packed {
      logic [dtio_pkg::SLOT_W-1:0] slot;
      dtio_pkg::outcome_type       outcome;
   } placement_type;

   logic [dtio_pkg::VENDOR_W-1:0]  tbl_vendor  [ENTRIES];
   logic [dtio_pkg::ADDRESS_W-1:0] tbl_address [ENTRIES];
   logic [dtio_pkg::TIME_W-1:0]    tbl_time    [ENTRIES];

   placement_type expected_placements[$];

   // Key match on a used entry first, then lowest free entry, then smallest
   // timestamp with the lowest index taking a tie.
   function automatic placement_type place_record(
      input logic [dtio_pkg::VENDOR_W-1:0]  vid,
      input logic [dtio_pkg::ADDRESS_W-1:0] addr);
      placement_type               p;
      bit                          found;
      int                          best;
      logic [dtio_pkg::TIME_W-1:0] oldest;
      found = 1'b0;
      p.slot = '0;
      p.outcome = dtio_pkg::OUTCOME_MATCH;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && tbl_time[i] != '0 && tbl_vendor[i] == vid &&
             tbl_address[i] == addr) begin
            p.slot = dtio_pkg::SLOT_W'(i);
            p.outcome = dtio_pkg::OUTCOME_MATCH;
            found = 1'b1;
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && tbl_time[i] == '0) begin
            p.slot = dtio_pkg::SLOT_W'(i);
            p.outcome = dtio_pkg::OUTCOME_FREE;
            found = 1'b1;
         end
      end
      if (!found) begin
         best = 0;
         oldest = tbl_time[0];
         for (int i = 1; i < ENTRIES; i++) begin
            if (tbl_time[i] < oldest) begin
               oldest = tbl_time[i];
               best = i;
            end
         end
         p.slot = dtio_pkg::SLOT_W'(best);
         p.outcome = dtio_pkg::OUTCOME_OLDEST;
      end
      return p;
   endfunction

   always @(posedge clock) begin : track
      placement_type placed;
      placement_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tbl_vendor[i]  <= '0;
            tbl_address[i] <= '0;
            tbl_time[i]    <= '0;
         end
         expected_placements.delete();
         mismatch_count = 0;
         match_seen = 0;
         free_seen = 0;
         oldest_seen = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            placed = place_record(req_mon.vendor_id, req_mon.device_address);
            tbl_vendor[placed.slot]  <= req_mon.vendor_id;
            tbl_address[placed.slot] <= req_mon.device_address;
            tbl_time[placed.slot]    <= req_mon.receive_time;
            expected_placements.push_back(placed);
            case (placed.outcome)
               dtio_pkg::OUTCOME_MATCH: match_seen++;
               dtio_pkg::OUTCOME_FREE:  free_seen++;
               default:                 oldest_seen++;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_placements.size() == 0) begin
               $error("result word with no record outstanding: slot_index %0d, outcome %0d",
                      rsp_mon.slot_index, rsp_mon.outcome);
               mismatch_count++;
            end else begin
               want = expected_placements.pop_front();
               if (rsp_mon.slot_index !== want.slot) begin
                  $error("slot_index: expected %0d, actual %0d", want.slot, rsp_mon.slot_index);
                  mismatch_count++;
               end
               if (rsp_mon.outcome !== want.outcome) begin
                  $error("outcome: expected %0d, actual %0d", want.outcome, rsp_mon.outcome);
                  mismatch_count++;
               end
            end
         end
      end
      results_pending = expected_placements.size();
   end

endmodule

// ===== test/device_table_insert_oldest_evict_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_table_insert_oldest_evict_tb
// Drives device records into the table: a directed pass over key match,
// free fill, stale keys on freed entries, zero timestamps and tied oldest
// replacement, then random records from a small key pool under four flow
// phases. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module device_table_insert_oldest_evict_tb;

   localparam int PHASE_RECORDS = 288;
   localparam int KEY_POOL      = 24;
   localparam int SCAN_CYCLES   = 22;
   localparam int STALL_LIMIT   = 4000;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH_STALL
   } flow_mode_type;

   logic clock;
   logic reset;

   dtio_req_if req_ch ();
   dtio_rsp_if rsp_ch ();

   flow_mode_type               flow_mode = FLOW_FREE;
   int                          mismatch_count;
   int                          results_pending;
   int                          match_seen;
   int                          free_seen;
   int                          oldest_seen;
   int                          records_sent = 0;
   int                          quiet_cycles = 0;
   logic [23:0]                 key_pool [KEY_POOL];
   logic [dtio_pkg::TIME_W-1:0] now_sec = 32'd1000;

   device_table_insert_oldest_evict u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dtio_placement_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .match_seen      (match_seen),
      .free_seen       (free_seen),
      .oldest_seen     (oldest_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: stall by phase, change at the falling edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         case (flow_mode)
            FLOW_RECEIVER_STALL: rsp_ch.ready <= ($urandom_range(0, 99) >= 88);
            FLOW_BOTH_STALL:     rsp_ch.ready <= ($urandom_range(0, 99) >= 14);
            default:             rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic dtio_pkg::req_word_type record_of(
      input logic [dtio_pkg::VENDOR_W-1:0]  vid,
      input logic [dtio_pkg::ADDRESS_W-1:0] addr,
      input logic [dtio_pkg::TIME_W-1:0]    t,
      input logic [dtio_pkg::PAYLOAD_W-1:0] data);
      dtio_pkg::req_word_type w;
      w.vendor_id = vid;
      w.device_address = addr;
      w.receive_time = t;
      w.record_payload = data;
      return w;
   endfunction

   function automatic bit sender_idles();
      case (flow_mode)
         FLOW_SENDER_IDLE: return ($urandom_range(0, 99) < 88);
         FLOW_BOTH_STALL:  return ($urandom_range(0, 99) < 14);
         default:          return 1'b0;
      endcase
   endfunction

   // Mostly pool keys so matches and evictions both happen; the rest are
   // arbitrary keys. Timestamps mostly advance slowly, with repeats for ties.
   function automatic dtio_pkg::req_word_type random_record();
      logic [23:0]                 key;
      logic [dtio_pkg::TIME_W-1:0] t;
      int                          r;
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else key = 24'($urandom);
      r = $urandom_range(0, 99);
      if (r < 4) begin
         t = '0;
      end else if (r < 14) begin
         t = $urandom;
      end else begin
         now_sec = now_sec + $urandom_range(0, 3);
         t = now_sec;
      end
      return record_of(key[23:16], key[15:0], t, {$urandom, $urandom});
   endfunction

   // Called just after a falling edge; returns once the word is taken, just after a
   // falling edge, with valid still high so a back-to-back word needs no second assignment.
   task automatic send_record(input dtio_pkg::req_word_type w);
      while (sender_idles()) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.vendor_id      <= w.vendor_id;
      req_ch.device_address <= w.device_address;
      req_ch.receive_time   <= w.receive_time;
      req_ch.record_payload <= w.record_payload;
      do @(posedge clock); while (!req_ch.ready);
      records_sent++;
      @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.vendor_id = '0;
      req_ch.device_address = '0;
      req_ch.receive_time = '0;
      req_ch.record_payload = '0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 24'($urandom);
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, match, zero timestamp freeing a match, stale key
      // on a freed entry, full table, oldest replacement and a tie.
      send_record(record_of(8'h00, 16'h0000, 32'd1, 64'h0));
      send_record(record_of(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_record(record_of(8'h00, 16'h0000, 32'd5, 64'hA5A5_5A5A_0F0F_F0F0));
      send_record(record_of(8'hFF, 16'hFFFF, 32'd0, 64'h1234_5678_9ABC_DEF0));
      send_record(record_of(8'hFF, 16'hFFFF, 32'd7, 64'h8000_0000_0000_0001));
      for (int i = 2; i < 16; i++) begin
         send_record(record_of(8'(i), 16'(i * 16'h1111), 32'd100, {$urandom, $urandom}));
      end
      send_record(record_of(8'h80, 16'h8000, 32'd100, {$urandom, $urandom}));
      send_record(record_of(8'h81, 16'h0001, 32'd100, {$urandom, $urandom}));
      send_record(record_of(8'h82, 16'h7FFF, 32'd300, {$urandom, $urandom}));
      send_record(record_of(8'h05, 16'h5555, 32'd0, {$urandom, $urandom}));
      send_record(record_of(8'h7F, 16'h00FF, 32'd1, {$urandom, $urandom}));

      for (int ph = FLOW_FREE; ph <= FLOW_BOTH_STALL; ph++) begin
         flow_mode = flow_mode_type'(ph);
         for (int n = 0; n < PHASE_RECORDS; n++) send_record(random_record());
      end
      req_ch.valid <= 1'b0;
      flow_mode = FLOW_FREE;

      // Drain outstanding results, then give the block time to settle.
      while (results_pending != 0) @(negedge clock);
      repeat (2 * SCAN_CYCLES) @(negedge clock);

      $display("Sent %0d records across free-flow, sender-gap, receiver-stall and mixed phases.",
               records_sent);
      $display("Outcomes: %0d key matches, %0d free fills, %0d oldest replacements.",
               match_seen, free_seen, oldest_seen);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
